### rtl/assert_macros.svh
// Assertion macros shared by the queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define PMQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define PMQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pmq_pkg.sv
// Package with the codes, types and helpers of the priority message queue.
package pmq_pkg;

	localparam logic [1:0] CMD_SEND  = 2'd0;
	localparam logic [1:0] CMD_RECV  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BLOCK = 2'd1;
	localparam logic [1:0] ST_LEN   = 2'd2;

	localparam logic REG_QUEUE_DEPTH  = 1'b0;
	localparam logic REG_MESSAGE_SIZE = 1'b1;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LATCH,
		OP_SEND_RD,
		OP_SEND_UPD,
		OP_WALK,
		OP_LINK_RD,
		OP_LINK_A,
		OP_LINK_B,
		OP_RECV_RD,
		OP_RECV_UPD,
		OP_CLEAR,
		OP_RESULT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SEND_UPD,
		S_WALK,
		S_LINK_RD,
		S_LINK_A,
		S_LINK_B,
		S_RECV_UPD,
		S_DONE
	} state_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       len_bad;
		logic       full;
		logic       empty;
		logic       prio_gt;
	} dp_stat_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < nbytes) begin
				m[i*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

### rtl/priority_message_queue_core.sv
// Top level of the priority message queue: sequencer plus datapath.
// One item is taken at a time. After its check, a rejected, clear or unused command goes
// straight to the result; a receive and a send into an empty queue pass their update state
// first; a send that becomes the new head passes its update state, then the link read and
// link write states; any other send, between those, walks backward from the tail past each
// queued message of lower priority, reading one list entry per cycle from the slot memories.
// The next item is accepted in the cycle after the result appears, and a result held by
// out_stall delays the result of the following item until it leaves. Within a priority,
// messages leave in the order they were sent. A queue_depth write takes effect at the next
// clear command. A new item is accepted while a result waits.
module priority_message_queue_core #(
	parameter int DEPTH     = 16,
	parameter int MSG_BYTES = 8,
	parameter int PRIO_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [63:0] payload_in,
	input  logic [3:0]  length,
	input  logic [7:0]  priority_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] payload_out,
	output logic [7:0]  priority_out,
	output logic [4:0]  fill_count
);

	pmq_pkg::dp_cmd_t  dcmd;
	pmq_pkg::dp_stat_t stat;

	pmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.dcmd      (dcmd)
	);

	pmq_datapath #(
		.DEPTH     (DEPTH),
		.MSG_BYTES (MSG_BYTES),
		.PRIO_BITS (PRIO_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.payload_in   (payload_in),
		.length       (length),
		.priority_in  (priority_in),
		.dcmd         (dcmd),
		.stat         (stat),
		.status       (status),
		.payload_out  (payload_out),
		.priority_out (priority_out),
		.fill_count   (fill_count)
	);

endmodule

### rtl/pmq_ctrl.sv
// Sequencer that steps the queue datapath through each command.
`include "assert_macros.svh"

module pmq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  pmq_pkg::dp_stat_t stat,
	output pmq_pkg::dp_cmd_t  dcmd
);

	pmq_pkg::state_t state_q, state_d;
	logic [1:0] code_q, code_d;
	logic out_valid_q, out_valid_d;
	logic walk_src;
	logic in_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pmq_pkg::S_IDLE;
			code_q      <= pmq_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			code_q      <= code_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		code_d      = code_q;
		out_valid_d = out_valid_q && out_stall;
		dcmd.op     = pmq_pkg::OP_IDLE;
		dcmd.code   = code_q;
		unique case (state_q)
			pmq_pkg::S_IDLE: begin
				if (in_valid) begin
					dcmd.op = pmq_pkg::OP_LATCH;
					state_d = pmq_pkg::S_CHECK;
				end
			end
			pmq_pkg::S_CHECK: begin
				code_d  = pmq_pkg::ST_OK;
				state_d = pmq_pkg::S_DONE;
				unique case (stat.cmd)
					pmq_pkg::CMD_SEND: begin
						if (stat.len_bad) begin
							code_d = pmq_pkg::ST_LEN;
						end else if (stat.full) begin
							code_d = pmq_pkg::ST_BLOCK;
						end else begin
							dcmd.op = pmq_pkg::OP_SEND_RD;
							state_d = pmq_pkg::S_SEND_UPD;
						end
					end
					pmq_pkg::CMD_RECV: begin
						if (stat.len_bad) begin
							code_d = pmq_pkg::ST_LEN;
						end else if (stat.empty) begin
							code_d = pmq_pkg::ST_BLOCK;
						end else begin
							dcmd.op = pmq_pkg::OP_RECV_RD;
							state_d = pmq_pkg::S_RECV_UPD;
						end
					end
					pmq_pkg::CMD_CLEAR: begin
						dcmd.op = pmq_pkg::OP_CLEAR;
					end
					default: ;
				endcase
			end
			pmq_pkg::S_SEND_UPD: begin
				dcmd.op = pmq_pkg::OP_SEND_UPD;
				if (stat.empty) begin
					state_d = pmq_pkg::S_DONE;
				end else if (stat.prio_gt) begin
					state_d = pmq_pkg::S_LINK_RD;
				end else begin
					state_d = pmq_pkg::S_WALK;
				end
			end
			pmq_pkg::S_WALK: begin
				dcmd.op = pmq_pkg::OP_WALK;
				if (!stat.prio_gt) begin
					state_d = pmq_pkg::S_LINK_RD;
				end
			end
			pmq_pkg::S_LINK_RD: begin
				dcmd.op = pmq_pkg::OP_LINK_RD;
				state_d = pmq_pkg::S_LINK_A;
			end
			pmq_pkg::S_LINK_A: begin
				dcmd.op = pmq_pkg::OP_LINK_A;
				state_d = pmq_pkg::S_LINK_B;
			end
			pmq_pkg::S_LINK_B: begin
				dcmd.op = pmq_pkg::OP_LINK_B;
				state_d = pmq_pkg::S_DONE;
			end
			pmq_pkg::S_RECV_UPD: begin
				dcmd.op = pmq_pkg::OP_RECV_UPD;
				state_d = pmq_pkg::S_DONE;
			end
			pmq_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					dcmd.op     = pmq_pkg::OP_RESULT;
					out_valid_d = 1'b1;
					state_d     = pmq_pkg::S_IDLE;
				end
			end
			default: state_d = pmq_pkg::S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != pmq_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign walk_src  = (state_q == pmq_pkg::S_SEND_UPD) || (state_q == pmq_pkg::S_WALK);
	assign in_done   = (state_q == pmq_pkg::S_DONE);

	`PMQ_ASSERT(a_walk_entry, (state_q == pmq_pkg::S_WALK) |-> $past(walk_src), "bad walk entry")
	`PMQ_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(in_done), "result outside done")

endmodule

### rtl/pmq_datapath.sv
// Datapath of the queue: slot memories, list pointers, configuration and result registers.
`include "assert_macros.svh"

module pmq_datapath #(
	parameter int DEPTH     = 16,
	parameter int MSG_BYTES = 8,
	parameter int PRIO_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [4:0]        cfg_data,
	input  logic [1:0]        cmd,
	input  logic [63:0]       payload_in,
	input  logic [3:0]        length,
	input  logic [7:0]        priority_in,
	input  pmq_pkg::dp_cmd_t  dcmd,
	output pmq_pkg::dp_stat_t stat,
	output logic [1:0]        status,
	output logic [63:0]       payload_out,
	output logic [7:0]        priority_out,
	output logic [4:0]        fill_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int MW = 8 * MSG_BYTES;
	localparam logic [FW-1:0] NULL_SLOT = FW'(DEPTH);
	localparam logic [4:0] QD_RST = 5'((DEPTH > 31) ? 31 : DEPTH);

	logic [4:0] qd_q;
	logic [3:0] ms_q;
	logic [FW-1:0] depth_q, depth_eff;
	logic [3:0] size_eff;

	logic [1:0] cmd_q;
	logic [MW-1:0] pay_q;
	logic [3:0] len_q;
	logic [PRIO_BITS-1:0] prio_q;

	logic [FW-1:0] free_head_q, fresh_q, count_q;
	logic [AW-1:0] head_q, ix_q, s_q, after_q;
	logic s_fresh_q;

	logic [MW-1:0] res_pay_q;
	logic [PRIO_BITS-1:0] res_prio_q;

	logic [MW-1:0] msg_mem [DEPTH];
	logic [PRIO_BITS-1:0] prio_mem [DEPTH];
	logic [AW-1:0] prev_mem [DEPTH];
	logic [AW-1:0] next_mem [DEPTH];
	logic [FW-1:0] free_mem [DEPTH];

	logic [MW-1:0] msg_rd;
	logic [PRIO_BITS-1:0] prio_rd;
	logic [AW-1:0] prev_rd, next_rd;
	logic [FW-1:0] free_rd;

	logic [AW-1:0] rd_a;
	logic prev_we, next_we;
	logic [AW-1:0] prev_wa, prev_wd, next_wa, next_wd;
	logic [FW-1:0] fresh_inc;
	logic [63:0] len_mask;

	always_comb begin
		if (qd_q == '0) begin
			depth_eff = FW'(1);
		end else if (32'(qd_q) > DEPTH) begin
			depth_eff = FW'(DEPTH);
		end else begin
			depth_eff = FW'(qd_q);
		end
		size_eff = (32'(ms_q) > MSG_BYTES) ? 4'(MSG_BYTES) : ms_q;
	end

	assign len_mask  = pmq_pkg::byte_mask(len_q);
	assign fresh_inc = fresh_q + FW'(1);

	assign stat.cmd     = cmd_q;
	assign stat.len_bad = (len_q > size_eff);
	assign stat.full    = (free_head_q == NULL_SLOT);
	assign stat.empty   = (count_q == '0);
	assign stat.prio_gt = (prio_q > prio_rd);

	always_comb begin
		if (dcmd.op == pmq_pkg::OP_SEND_UPD || dcmd.op == pmq_pkg::OP_WALK) begin
			rd_a = prev_rd;
		end else if (dcmd.op == pmq_pkg::OP_LINK_RD) begin
			rd_a = ix_q;
		end else begin
			rd_a = head_q;
		end
	end

	always_comb begin
		prev_we = 1'b0;
		next_we = 1'b0;
		prev_wa = s_q;
		prev_wd = s_q;
		next_wa = s_q;
		next_wd = s_q;
		unique case (dcmd.op)
			pmq_pkg::OP_SEND_UPD: begin
				prev_we = stat.empty;
				next_we = stat.empty;
			end
			pmq_pkg::OP_LINK_A: begin
				prev_we = 1'b1;
				prev_wd = ix_q;
				next_we = 1'b1;
				next_wd = next_rd;
			end
			pmq_pkg::OP_LINK_B: begin
				prev_we = 1'b1;
				prev_wa = after_q;
				next_we = 1'b1;
				next_wa = ix_q;
			end
			pmq_pkg::OP_RECV_UPD: begin
				prev_we = (count_q > FW'(1));
				prev_wa = next_rd;
				prev_wd = prev_rd;
				next_we = (count_q > FW'(1));
				next_wa = prev_rd;
				next_wd = next_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dcmd.op == pmq_pkg::OP_SEND_RD) begin
			msg_mem[free_head_q[AW-1:0]]  <= pay_q & len_mask[MW-1:0];
			prio_mem[free_head_q[AW-1:0]] <= prio_q;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (dcmd.op == pmq_pkg::OP_RECV_UPD) begin
			free_mem[head_q] <= free_head_q;
		end
		msg_rd  <= msg_mem[rd_a];
		prio_rd <= prio_mem[rd_a];
		prev_rd <= prev_mem[rd_a];
		next_rd <= next_mem[rd_a];
		free_rd <= free_mem[free_head_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (dcmd.op == pmq_pkg::OP_LATCH) begin
			cmd_q      <= cmd;
			pay_q      <= payload_in[MW-1:0];
			len_q      <= length;
			prio_q     <= priority_in[PRIO_BITS-1:0];
			res_pay_q  <= '0;
			res_prio_q <= '0;
		end
		if (dcmd.op == pmq_pkg::OP_SEND_RD) begin
			s_q       <= free_head_q[AW-1:0];
			s_fresh_q <= (free_head_q == fresh_q);
		end
		if (dcmd.op == pmq_pkg::OP_SEND_UPD || (dcmd.op == pmq_pkg::OP_WALK && stat.prio_gt)) begin
			ix_q <= prev_rd;
		end
		if (dcmd.op == pmq_pkg::OP_LINK_A) begin
			after_q <= next_rd;
		end
		if (dcmd.op == pmq_pkg::OP_RECV_UPD) begin
			res_pay_q  <= msg_rd & len_mask[MW-1:0];
			res_prio_q <= prio_rd;
		end
		if (dcmd.op == pmq_pkg::OP_RESULT) begin
			status       <= dcmd.code;
			payload_out  <= 64'(res_pay_q);
			priority_out <= 8'(res_prio_q);
			fill_count   <= 5'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qd_q        <= QD_RST;
			ms_q        <= 4'(MSG_BYTES);
			depth_q     <= FW'(QD_RST);
			free_head_q <= '0;
			fresh_q     <= '0;
			head_q      <= '0;
			count_q     <= '0;
		end else begin
			if (cfg_we && cfg_index == pmq_pkg::REG_QUEUE_DEPTH) begin
				qd_q <= cfg_data;
			end
			if (cfg_we && cfg_index == pmq_pkg::REG_MESSAGE_SIZE) begin
				ms_q <= cfg_data[3:0];
			end
			unique case (dcmd.op)
				pmq_pkg::OP_CLEAR: begin
					depth_q     <= depth_eff;
					free_head_q <= '0;
					fresh_q     <= '0;
					head_q      <= '0;
					count_q     <= '0;
				end
				pmq_pkg::OP_SEND_UPD: begin
					if (s_fresh_q) begin
						fresh_q     <= fresh_inc;
						free_head_q <= (fresh_inc < depth_q) ? fresh_inc : NULL_SLOT;
					end else begin
						free_head_q <= free_rd;
					end
					if (stat.empty || stat.prio_gt) begin
						head_q <= s_q;
					end
					count_q <= count_q + FW'(1);
				end
				pmq_pkg::OP_RECV_UPD: begin
					head_q      <= (count_q > FW'(1)) ? next_rd : '0;
					free_head_q <= FW'(head_q);
					count_q     <= count_q - FW'(1);
				end
				default: ;
			endcase
		end
	end

	`PMQ_ASSERT(a_count_bound, count_q <= depth_q, "message count above depth")
	`PMQ_ASSERT(a_full_match, (free_head_q == NULL_SLOT) == (count_q == depth_q), "free list and count disagree")
	`PMQ_ASSERT(a_fresh_bound, fresh_q <= depth_q, "fresh slot pointer beyond depth")

endmodule

### tb/priority_message_queue_core_test.sv
// Self-checking testbench for the priority message queue core with a predictor scoreboard.
module priority_message_queue_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int MSG_BYTES = 8;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  status;
		logic [63:0] payload;
		logic [7:0]  prio;
		logic [4:0]  fill;
	} reply_t;

	class queue_scoreboard;
		logic [4:0]  depth_reg;
		logic [3:0]  size_reg;
		logic [63:0] msgs [DEPTH];
		logic [7:0]  prios [DEPTH];
		int          prv [DEPTH];
		int          nxt [DEPTH];
		int          free_nxt [DEPTH];
		int          free_top;
		int          head;
		int          count;
		reply_t      pending [$];
		int          errors;

		function new();
			depth_reg = 5'(DEPTH);
			size_reg = 4'(MSG_BYTES);
			errors = 0;
			rebuild();
		endfunction

		function void rebuild();
			int d;
			d = int'(depth_reg);
			if (d < 1) d = 1;
			if (d > DEPTH) d = DEPTH;
			for (int i = 0; i < DEPTH; i++) free_nxt[i] = (i + 1 < d) ? i + 1 : DEPTH;
			free_top = 0;
			head = 0;
			count = 0;
		endfunction

		function logic [63:0] mask_of(int n);
			return (n >= 8) ? '1 : ((64'd1 << (n * 8)) - 64'd1);
		endfunction

		function void note_item(logic [1:0] c, logic [63:0] pl, logic [3:0] len,
				logic [7:0] pr);
			reply_t r;
			int s, ix, after, steps, p, n, sz;
			sz = (int'(size_reg) > MSG_BYTES) ? MSG_BYTES : int'(size_reg);
			r.status = pmq_pkg::ST_OK;
			r.payload = '0;
			r.prio = '0;
			if (c == pmq_pkg::CMD_SEND) begin
				if (int'(len) > sz) r.status = pmq_pkg::ST_LEN;
				else if (free_top >= DEPTH) r.status = pmq_pkg::ST_BLOCK;
				else begin
					s = free_top;
					free_top = free_nxt[s];
					prios[s] = pr;
					msgs[s] = pl & mask_of(int'(len));
					if (count == 0) begin
						head = s;
						prv[s] = s;
						nxt[s] = s;
					end else begin
						ix = prv[head];
						steps = 0;
						if (pr > prios[head]) head = s;
						else
							while (pr > prios[ix] && steps < DEPTH) begin
								ix = prv[ix];
								steps++;
							end
						after = nxt[ix];
						prv[s] = ix;
						nxt[s] = after;
						nxt[ix] = s;
						prv[after] = s;
					end
					count++;
				end
			end else if (c == pmq_pkg::CMD_RECV) begin
				if (int'(len) > sz) r.status = pmq_pkg::ST_LEN;
				else if (count == 0) r.status = pmq_pkg::ST_BLOCK;
				else begin
					s = head;
					r.payload = msgs[s] & mask_of(int'(len));
					r.prio = prios[s];
					if (count > 1) begin
						p = prv[s];
						n = nxt[s];
						prv[n] = p;
						nxt[p] = n;
						head = n;
					end else head = 0;
					free_nxt[s] = free_top;
					free_top = s;
					count--;
				end
			end else if (c == pmq_pkg::CMD_CLEAR) rebuild();
			r.fill = 5'(count);
			pending.push_back(r);
		endfunction

		function void check_reply(reply_t got);
			reply_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result status=%0d", got.status);
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status || got.payload !== e.payload ||
					got.prio !== e.prio || got.fill !== e.fill) begin
				errors++;
				if (errors <= 10)
					$display("exp st=%0d pl=%h pr=%0d fc=%0d got st=%0d pl=%h pr=%0d fc=%0d",
						e.status, e.payload, e.prio, e.fill,
						got.status, got.payload, got.prio, got.fill);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0, cfg_index = 0;
	logic [4:0] cfg_data = '0;
	logic in_valid = 0, in_stall;
	logic [1:0] cmd = '0;
	logic [63:0] payload_in = '0;
	logic [3:0] length = '0;
	logic [7:0] priority_in = '0;
	logic out_valid, out_stall = 0;
	logic [1:0] status;
	logic [63:0] payload_out;
	logic [7:0] priority_out;
	logic [4:0] fill_count;

	queue_scoreboard board;
	bit quiet = 0;
	bit hold_req = 0;

	priority_message_queue_core uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		reply_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.status = status;
			r.payload = payload_out;
			r.prio = priority_out;
			r.fill = fill_count;
			board.check_reply(r);
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (300) @(negedge clk);
				hold_req = 0;
				out_stall <= 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 17);
				out_stall <= 1;
				repeat (gap) @(negedge clk);
				out_stall <= 0;
			end
		end
	end

	task automatic send_item(logic [1:0] c, logic [63:0] pl, logic [3:0] len, logic [7:0] pr);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		payload_in <= pl;
		length <= len;
		priority_in <= pr;
		do @(posedge clk); while (in_stall);
		board.note_item(c, pl, len, pr);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [4:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == pmq_pkg::REG_QUEUE_DEPTH) board.depth_reg = val;
		else board.size_reg = val[3:0];
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_item(int size_hi);
		int k;
		logic [1:0] c;
		logic [3:0] len;
		k = $urandom_range(0, 99);
		if (k < 50) c = pmq_pkg::CMD_SEND;
		else if (k < 94) c = pmq_pkg::CMD_RECV;
		else if (k < 97) c = pmq_pkg::CMD_CLEAR;
		else c = CMD_UNUSED;
		len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(0, size_hi));
		send_item(c, rand64(), len, ($urandom_range(0, 1)) ? 8'($urandom_range(0, 3))
			: 8'($urandom));
	endtask

	initial begin
		int depths [4] = '{16, 1, 0, 5};
		int sizes [4] = '{8, 0, 15, 3};
		board = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_item(pmq_pkg::CMD_RECV, '0, '0, '0);
		send_item(pmq_pkg::CMD_SEND, '1, 4'd8, 8'hFF);
		send_item(pmq_pkg::CMD_SEND, 64'h0123456789ABCDEF, 4'd3, 8'h00);
		send_item(pmq_pkg::CMD_SEND, rand64(), 4'd8, 8'hFF);
		send_item(pmq_pkg::CMD_SEND, rand64(), 4'd9, 8'h10);
		send_item(pmq_pkg::CMD_SEND, rand64(), 4'd15, 8'h10);
		send_item(pmq_pkg::CMD_SEND, rand64(), 4'd0, 8'h80);
		send_item(CMD_UNUSED, '1, 4'd15, 8'hFF);
		send_item(pmq_pkg::CMD_RECV, '0, 4'd15, '0);
		send_item(pmq_pkg::CMD_RECV, '0, '0, '0);
		for (int i = 0; i < 4; i++) send_item(pmq_pkg::CMD_RECV, '0, 4'd8, '0);
		for (int i = 0; i < 17; i++) send_item(pmq_pkg::CMD_SEND, rand64(), 4'd8, 8'(i % 3));
		send_item(pmq_pkg::CMD_CLEAR, '0, '0, '0);

		hold_req = 1;
		for (int i = 0; i < 30; i++) send_item(pmq_pkg::CMD_SEND, rand64(), 4'd8, 8'($urandom));
		for (int i = 0; i < 20; i++) send_item(pmq_pkg::CMD_RECV, '0, 4'd8, '0);

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_reg(pmq_pkg::REG_QUEUE_DEPTH, 5'(depths[ph]));
			write_reg(pmq_pkg::REG_MESSAGE_SIZE, 5'(sizes[ph]));
			send_item(pmq_pkg::CMD_CLEAR, '0, '0, '0);
			for (int i = 0; i < 170; i++) random_item(sizes[ph] > 8 ? 8 : sizes[ph]);
		end
		drain();
		write_reg(pmq_pkg::REG_QUEUE_DEPTH, 5'd31);
		write_reg(pmq_pkg::REG_MESSAGE_SIZE, 5'd8);
		send_item(pmq_pkg::CMD_CLEAR, '0, '0, '0);
		quiet = 1;
		for (int i = 0; i < 100; i++) random_item(8);
		drain();
		if (board.errors == 0 && board.pending.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
